FILE: rtl/itoa_pkg.sv
// Package for integer_to_ascii_digits: word types, format codes, FSM state,
// controller/datapath command and status structs, digit character table.
// No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int ValueWidth   = 32;
  localparam int BufDepth     = 10;
  localparam int MaxOut       = 11;
  localparam int IdxWidth     = 4;
  localparam int StepWidth    = 6;
  localparam int DefDecDigits = 10;
  localparam int DefHexDigits = 8;

  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;

  localparam logic [6:0] CHAR_MINUS = 7'h2d;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [3:0]  min_digits;
  } in_word_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SCAN,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic scan;
    logic emit_sign;
    logic emit_digit;
  } ctrl_t;

  typedef struct packed {
    logic hex;
    logic negative;
    logic steps_done;
    logic top_nonzero;
    logic idx_zero;
    logic out_free;
  } stat_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = 7'h30 + {3'b000, d};
    end else begin
      c = 7'h57 + {3'b000, d};
    end
    return c;
  endfunction

endpackage

FILE: rtl/itoa_ctrl.sv
// Controller FSM for integer_to_ascii_digits: sequences load, shift-add-3
// conversion, leading-zero scan, sign and digit emission.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  itoa_pkg::stat_t stat,
  output itoa_pkg::ctrl_t ctrl
);

  itoa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = itoa_pkg::ST_DABBLE;
        end
      end
      itoa_pkg::ST_DABBLE: begin
        if (stat.hex) begin
          state_next = itoa_pkg::ST_DIGIT;
        end else if (stat.steps_done) begin
          state_next = itoa_pkg::ST_SCAN;
        end
      end
      itoa_pkg::ST_SCAN: begin
        if (stat.top_nonzero || stat.idx_zero) begin
          state_next = stat.negative ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (stat.out_free) begin
          state_next = itoa_pkg::ST_DIGIT;
        end
      end
      itoa_pkg::ST_DIGIT: begin
        if (stat.out_free && stat.idx_zero) begin
          state_next = itoa_pkg::ST_IDLE;
        end
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    item_stall = 1'b1;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        ctrl.load  = item_valid;
      end
      itoa_pkg::ST_DABBLE: begin
        ctrl.dabble = !stat.hex && !stat.steps_done;
      end
      itoa_pkg::ST_SCAN: begin
        ctrl.scan = !(stat.top_nonzero || stat.idx_zero);
      end
      itoa_pkg::ST_SIGN: begin
        ctrl.emit_sign = stat.out_free;
      end
      itoa_pkg::ST_DIGIT: begin
        ctrl.emit_digit = stat.out_free;
      end
      default: ctrl = '0;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit_sign || ctrl.emit_digit) |-> stat.out_free)
    else $error("emit while output register busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctrl))
    else $error("more than one datapath command");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit_digit && stat.idx_zero) |=> (state == itoa_pkg::ST_IDLE))
    else $error("final digit did not end the item");

endmodule

FILE: rtl/itoa_dpath.sv
// Datapath for integer_to_ascii_digits: work value, BCD digit buffer,
// digit index, hex digit count and the output word register.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_dpath #(
  parameter int DEC_DIGITS = itoa_pkg::DefDecDigits,
  parameter int HEX_DIGITS = itoa_pkg::DefHexDigits
) (
  input  logic                clk,
  input  logic                rst,
  input  itoa_pkg::in_word_t  item,
  input  itoa_pkg::ctrl_t     ctrl,
  output itoa_pkg::stat_t     stat,
  input  logic                chr_stall,
  output logic                chr_valid,
  output itoa_pkg::out_word_t chr
);

  localparam int DecLimit = (DEC_DIGITS > itoa_pkg::BufDepth) ? itoa_pkg::BufDepth : DEC_DIGITS;
  localparam int HexCapI  = (HEX_DIGITS > 16) ? 16 : HEX_DIGITS;
  localparam logic [4:0] HexCap = 5'(HexCapI);
  localparam logic [4:0] OutCap = 5'(itoa_pkg::MaxOut);
  localparam logic [itoa_pkg::IdxWidth-1:0] DecTop  = itoa_pkg::IdxWidth'(DecLimit - 1);
  localparam logic [itoa_pkg::IdxWidth-1:0] BufLim  = itoa_pkg::IdxWidth'(itoa_pkg::BufDepth);
  localparam logic [itoa_pkg::StepWidth-1:0] Steps  =
    itoa_pkg::StepWidth'(itoa_pkg::ValueWidth);

  logic [31:0]                      work_value;
  logic [3:0]                       digit_buffer [itoa_pkg::BufDepth];
  logic                             negative_flag;
  logic                             hex_mode;
  logic [itoa_pkg::StepWidth-1:0]   step_count;
  logic [itoa_pkg::IdxWidth-1:0]    emit_index;

  logic [3:0]  adj [itoa_pkg::BufDepth];
  logic [4:0]  nd, pad, hex_n;
  logic [31:0] hex_sh;
  logic [3:0]  cur_digit, dec_digit;
  logic        emit;
  logic        bad_digit;

  // significant hex digits of the incoming value, padded and clamped
  always_comb begin
    nd = 5'd0;
    for (int i = 0; i < 8; i++) begin
      if (item.value[4*i +: 4] != 4'd0) begin
        nd = 5'(i + 1);
      end
    end
    pad   = ({1'b0, item.min_digits} > HexCap) ? HexCap : {1'b0, item.min_digits};
    hex_n = (pad > nd) ? pad : nd;
    if (hex_n == 5'd0) begin
      hex_n = 5'd1;
    end
    if (hex_n > OutCap) begin
      hex_n = OutCap;
    end
  end

  always_comb begin
    for (int i = 0; i < itoa_pkg::BufDepth; i++) begin
      adj[i] = (digit_buffer[i] >= 4'd5) ? digit_buffer[i] + 4'd3 : digit_buffer[i];
    end
  end

  always_comb begin
    hex_sh    = work_value >> {emit_index[2:0], 2'b00};
    dec_digit = (emit_index < BufLim) ? digit_buffer[emit_index] : 4'd0;
    if (hex_mode) begin
      cur_digit = emit_index[3] ? 4'd0 : hex_sh[3:0];
    end else begin
      cur_digit = dec_digit;
    end
  end

  assign emit = ctrl.emit_sign || ctrl.emit_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_value    <= '0;
      negative_flag <= 1'b0;
      hex_mode      <= 1'b0;
      step_count    <= '0;
      emit_index    <= '0;
    end else if (ctrl.load) begin
      hex_mode   <= (item.kind == itoa_pkg::KIND_HEX);
      step_count <= '0;
      for (int i = 0; i < itoa_pkg::BufDepth; i++) begin
        digit_buffer[i] <= 4'd0;
      end
      if (item.kind == itoa_pkg::KIND_SDEC && item.value[31]) begin
        work_value    <= ~item.value + 32'd1;
        negative_flag <= 1'b1;
      end else begin
        work_value    <= item.value;
        negative_flag <= 1'b0;
      end
      if (item.kind == itoa_pkg::KIND_HEX) begin
        emit_index <= itoa_pkg::IdxWidth'(hex_n - 5'd1);
      end else begin
        emit_index <= DecTop;
      end
    end else if (ctrl.dabble) begin
      digit_buffer[0] <= {adj[0][2:0], work_value[31]};
      for (int i = 1; i < itoa_pkg::BufDepth; i++) begin
        digit_buffer[i] <= {adj[i][2:0], adj[i-1][3]};
      end
      work_value <= {work_value[30:0], 1'b0};
      step_count <= step_count + itoa_pkg::StepWidth'(1);
    end else if (ctrl.scan || (ctrl.emit_digit && emit_index != '0)) begin
      emit_index <= emit_index - itoa_pkg::IdxWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (emit) begin
      chr_valid <= 1'b1;
    end else if (!chr_stall) begin
      chr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_sign) begin
      chr.char_out <= itoa_pkg::CHAR_MINUS;
      chr.last     <= 1'b0;
    end else if (ctrl.emit_digit) begin
      chr.char_out <= itoa_pkg::digit_char(cur_digit);
      chr.last     <= (emit_index == '0);
    end
  end

  always_comb begin
    stat.hex         = hex_mode;
    stat.negative    = negative_flag;
    stat.steps_done  = (step_count == Steps);
    stat.top_nonzero = (dec_digit != 4'd0);
    stat.idx_zero    = (emit_index == '0);
    stat.out_free    = !chr_valid || !chr_stall;
  end

  always_comb begin
    bad_digit = 1'b0;
    for (int i = 0; i < itoa_pkg::BufDepth; i++) begin
      if (digit_buffer[i] > 4'd9) begin
        bad_digit = 1'b1;
      end
    end
  end

  a_steps: assert property (@(posedge clk) disable iff (rst)
    !ctrl.load |-> (step_count <= Steps))
    else $error("conversion step count overran");

  a_bcd: assert property (@(posedge clk) disable iff (rst)
    $past(ctrl.dabble) |-> !bad_digit)
    else $error("BCD digit out of range");

  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit_digit && emit_index == '0) |=> (chr_valid && chr.last))
    else $error("final character missing last flag");

endmodule

FILE: rtl/integer_to_ascii_digits.sv
// Integer to ASCII digit converter, top level.
// Joins the controller FSM (itoa_ctrl) and the datapath (itoa_dpath).
// Depends on itoa_pkg.
//
// Usage:
//   Input channel item_valid/item_stall/item carries one word per number:
//   kind (unsigned decimal, signed decimal, hex), value and min_digits.
//   Output channel chr_valid/chr_stall/chr returns one word per ASCII
//   character, most significant first, with last set on the final one.
//   Decimal: load, then the shift-add-3 loop (one step per value bit) and
//   its exit, a leading-zero scan over the digit buffer, an optional sign,
//   then one digit per cycle while the output is not stalled.
//   Hex: load, a dispatch step, then one digit per cycle while the output
//   is not stalled, with up to 11 digits per number.
//   One number is in flight at a time; the conversion loop sets the rate.
//   The output word register lets the next number be taken while the
//   last character is still waiting. A stall on the output holds the word
//   and pauses emission. Reset (synchronous, active high) returns the
//   controller to idle and empties the output register.
`timescale 1ns / 1ps

module integer_to_ascii_digits #(
  parameter int DEC_DIGITS = itoa_pkg::DefDecDigits,
  parameter int HEX_DIGITS = itoa_pkg::DefHexDigits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  itoa_pkg::in_word_t  item,
  output logic                chr_valid,
  input  logic                chr_stall,
  output itoa_pkg::out_word_t chr
);

  itoa_pkg::ctrl_t ctrl;
  itoa_pkg::stat_t stat;

  itoa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  itoa_dpath #(
    .DEC_DIGITS (DEC_DIGITS),
    .HEX_DIGITS (HEX_DIGITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .ctrl      (ctrl),
    .stat      (stat),
    .chr_stall (chr_stall),
    .chr_valid (chr_valid),
    .chr       (chr)
  );

endmodule

FILE: tb/tb_top.sv
// Testbench for integer_to_ascii_digits: drives numbers in all format kinds,
// predicts the ASCII character words and checks them in order at the output.
// Depends on itoa_pkg and the integer_to_ascii_digits RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] KIND_ALT_UDEC = 2'd3;
  localparam int TailItems = 40;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic               drain;
    itoa_pkg::in_word_t w;
  } queued_item_t;

  logic                rst = 1'b1;
  logic                clk;
  logic                item_valid = 1'b0;
  logic                item_stall;
  itoa_pkg::in_word_t  item = '0;
  logic                chr_valid;
  logic                chr_stall = 1'b0;
  itoa_pkg::out_word_t chr;

  queued_item_t        pending_items[$];
  itoa_pkg::out_word_t expected_chars[$];
  string               hex_chars = "0123456789abcdef";
  int                  idle_pcts[3] = '{0, 8, 35};
  int                  send_pct = 0;
  int                  stall_pct = 0;
  int                  send_gap = 0;
  int                  stall_gap = 0;
  int                  cycle_count = 0;
  int                  mismatch_count = 0;

  integer_to_ascii_digits dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .chr_valid  (chr_valid),
    .chr_stall  (chr_stall),
    .chr        (chr)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic push_char(input logic [7:0] ch, input logic is_last);
    itoa_pkg::out_word_t c;
    c.char_out = ch[6:0];
    c.last     = is_last;
    expected_chars.push_back(c);
  endtask

  // expected characters for one number, most significant first
  task automatic push_expected_chars(input itoa_pkg::in_word_t w);
    logic [31:0] mag;
    logic [3:0]  digs[$];
    int          n;
    int          pad;
    mag = w.value;
    if (w.kind == itoa_pkg::KIND_HEX) begin
      n = 0;
      for (int k = 0; k < itoa_pkg::DefHexDigits; k++) begin
        if (w.value[4*k +: 4] != 4'd0) n = k + 1;
      end
      pad = (w.min_digits > itoa_pkg::DefHexDigits) ? itoa_pkg::DefHexDigits :
                                                      int'(w.min_digits);
      if (pad > n) n = pad;
      if (n == 0) n = 1;
      for (int k = n - 1; k >= 0; k--) begin
        push_char(hex_chars[w.value[4*k +: 4]], k == 0);
      end
    end else begin
      if (w.kind == itoa_pkg::KIND_SDEC && w.value[31]) begin
        mag = -w.value;
        push_char({1'b0, itoa_pkg::CHAR_MINUS}, 1'b0);
      end
      do begin
        digs.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      for (int k = 0; k < digs.size(); k++) begin
        push_char(hex_chars[digs[k]], k == digs.size() - 1);
      end
    end
  endtask

  task automatic add_item(input logic [1:0] kind, input logic [31:0] value,
                          input logic [3:0] min_digits, input logic drain);
    queued_item_t q;
    q.drain        = drain;
    q.w.kind       = kind;
    q.w.value      = value;
    q.w.min_digits = min_digits;
    pending_items.push_back(q);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 99);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      3: return p << $urandom_range(0, 31);
      4: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'hffff_ffff) ^ $urandom_range(0, 3);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [1:0] random_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return itoa_pkg::KIND_UDEC;
    if (r < 6) return itoa_pkg::KIND_SDEC;
    if (r < 9) return itoa_pkg::KIND_HEX;
    return KIND_ALT_UDEC;
  endfunction

  // sender side
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count % 256 == 0) send_pct = idle_pcts[$urandom_range(0, 2)];
      if (item_valid && !item_stall) begin
        push_expected_chars(item);
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].drain && expected_chars.size() != 0)) begin
          item_valid <= 1'b0;
        end else if (pending_items.size() > TailItems &&
                     $urandom_range(0, 99) < send_pct) begin
          send_gap = $urandom_range(1, 18) - 1;
          item_valid <= 1'b0;
        end else begin
          item       <= pending_items[0].w;
          item_valid <= 1'b1;
          void'(pending_items.pop_front());
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    itoa_pkg::out_word_t exp_word;
    if (rst) begin
      chr_stall <= 1'b0;
    end else begin
      if (cycle_count % 256 == 128) stall_pct = idle_pcts[$urandom_range(0, 2)];
      if (chr_valid && !chr_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word char_out=%h last=%b", $time, chr.char_out, chr.last);
          mismatch_count++;
        end else begin
          exp_word = expected_chars.pop_front();
          if (chr.char_out !== exp_word.char_out) begin
            $display("%0t: char_out expected %h actual %h", $time,
                     exp_word.char_out, chr.char_out);
            mismatch_count++;
          end
          if (chr.last !== exp_word.last) begin
            $display("%0t: last expected %b actual %b", $time, exp_word.last, chr.last);
            mismatch_count++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        chr_stall <= 1'b1;
      end else if (pending_items.size() > TailItems &&
                   $urandom_range(0, 99) < stall_pct) begin
        stall_gap = $urandom_range(1, 18) - 1;
        chr_stall <= 1'b1;
      end else begin
        chr_stall <= 1'b0;
      end
    end
  end

  initial begin
    add_item(itoa_pkg::KIND_UDEC, 32'd0, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_UDEC, 32'hffff_ffff, 4'd15, 1'b0);
    add_item(itoa_pkg::KIND_UDEC, 32'd1, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_UDEC, 32'd9, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_UDEC, 32'd10, 4'd8, 1'b0);
    add_item(itoa_pkg::KIND_UDEC, 32'd1_000_000_000, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_SDEC, 32'h8000_0000, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_SDEC, 32'hffff_ffff, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_SDEC, 32'h7fff_ffff, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_SDEC, 32'd0, 4'd0, 1'b1);
    add_item(itoa_pkg::KIND_SDEC, 32'hffff_fff6, 4'd3, 1'b0);
    add_item(KIND_ALT_UDEC, 32'd12345, 4'd0, 1'b0);
    add_item(KIND_ALT_UDEC, 32'hffff_ffff, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'd0, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'd0, 4'd8, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'd0, 4'd9, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'd0, 4'd15, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'hffff_ffff, 4'd0, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'hdead_beef, 4'd3, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'd1, 4'd5, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'h1234_5678, 4'd4, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'h0000_0abc, 4'd15, 1'b0);
    add_item(itoa_pkg::KIND_HEX, 32'h8000_0000, 4'd1, 1'b0);
    for (int i = 0; i < 357; i++) begin
      add_item(random_kind(), random_value(), 4'($urandom_range(0, 15)), i % 50 == 25);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
